// ----- src/sts_pkg.sv -----
package sts_pkg;

    localparam int DATA_W = 32;
    localparam int ID_W   = 8;

    localparam logic [1:0] K_ACK  = 2'd0;
    localparam logic [1:0] K_FIRE = 2'd1;
    localparam logic [1:0] K_DONE = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_WRAP    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_PARADOX = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SHOOT = 1'b1;

    localparam logic REG_DEFAULT_DELAY = 1'b0;
    localparam logic REG_LAG_LIMIT     = 1'b1;

    localparam logic [DATA_W-1:0] DEFAULT_DELAY_RST = 32'd1000;
    localparam logic [DATA_W-1:0] LAG_LIMIT_RST     = 32'd10000;

    typedef struct packed {
        logic [DATA_W-1:0] fire_time;
        logic [DATA_W-1:0] interval;
        logic [ID_W-1:0]   ident;
        logic              rep;
    } t_entry;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              sub;
    } t_alu_req;

endpackage

// ----- src/sts_ram.sv -----
module sts_ram #(
    parameter int WIDTH = 73,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sts_alu.sv -----
module sts_alu (
    input  sts_pkg::t_alu_req              i_req,
    output logic [sts_pkg::DATA_W-1:0]     o_sum,
    output logic                           o_carry
);

    import sts_pkg::*;

    logic [DATA_W-1:0] b_op;

    // subtract: carry high means a >= b; add: carry high means wrap
    assign b_op = i_req.sub ? ~i_req.b : i_req.b;
    assign {o_carry, o_sum} = {1'b0, i_req.a} + {1'b0, b_op} + {{DATA_W{1'b0}}, i_req.sub};

endmodule

// ----- src/sorted_timer_queue.sv -----
// add: a full queue is refused at once; else the fire time is summed and each queued timer
// later than the new one moves up a slot (read, compare, write) before the new one goes in
// shoot: each due timer fires and a repeating one is re-added as an add is; lag and fire
// limits are checked after each fire, and a done result ends it; one shared 32-bit adder and one
// ram port pair serve all steps; busy drops as the last result shows, the receiver cannot stall
// reset clears control and registers only, the timer ram needs no clearing pass
module sorted_timer_queue #(
    parameter int DEPTH     = 32,
    parameter int MAX_FIRES = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [sts_pkg::ID_W-1:0]    i_timer_id,
    input  logic [sts_pkg::DATA_W-1:0]  i_interval,
    input  logic                        i_repeat_req,
    input  logic [sts_pkg::DATA_W-1:0]  i_start_time,
    input  logic [sts_pkg::DATA_W-1:0]  i_now_time,
    output logic                        o_strobe,
    output logic [1:0]                  o_kind,
    output logic [sts_pkg::ID_W-1:0]    o_fired_id,
    output logic [sts_pkg::DATA_W-1:0]  o_fire_time,
    output logic [2:0]                  o_status,
    output logic [sts_pkg::DATA_W-1:0]  o_next_delay,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import sts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int FW = $clog2(MAX_FIRES + 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_ADD_SUM  = 9'b000000010,
        S_INS_CHK  = 9'b000000100,
        S_INS_WAIT = 9'b000001000,
        S_SH_READ  = 9'b000010000,
        S_SH_HEAD  = 9'b000100000,
        S_SH_REQ   = 9'b001000000,
        S_SH_LAG   = 9'b010000000,
        S_SH_FINAL = 9'b100000000
    } t_state;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_w, n_w;
    logic [CW-1:0]     r_k, n_k;
    logic [FW-1:0]     r_fires, n_fires;
    logic              r_stop, n_stop;
    logic              r_req_type, n_req_type;
    logic [DATA_W-1:0] r_default_delay, r_lag_limit;

    t_entry            r_ins, n_ins;
    t_entry            r_hd, n_hd;
    logic              r_wrap, n_wrap;
    logic [DATA_W-1:0] r_late, n_late;
    logic [ID_W-1:0]   r_id, n_id;
    logic [DATA_W-1:0] r_iv, n_iv;
    logic              r_rep, n_rep;
    logic [DATA_W-1:0] r_start, n_start;
    logic [DATA_W-1:0] r_now, n_now;

    logic              r_o_strobe, n_o_strobe;
    logic [1:0]        r_o_kind, n_o_kind;
    logic [ID_W-1:0]   r_o_id, n_o_id;
    logic [DATA_W-1:0] r_o_time, n_o_time;
    logic [2:0]        r_o_status, n_o_status;
    logic [DATA_W-1:0] r_o_delay, n_o_delay;
    logic              r_o_last, n_o_last;

    t_alu_req          alu_req;
    logic [DATA_W-1:0] alu_sum;
    logic              alu_carry;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    t_entry            ram_wdata;
    logic [EW-1:0]     ram_rdata;
    t_entry            ram_q;
    logic              ins_done;
    logic              cfg_wr;

    assign ram_q = ram_rdata;

    sts_alu u_alu (
        .i_req   (alu_req),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    sts_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_w        = r_w;
        n_k        = r_k;
        n_fires    = r_fires;
        n_stop     = r_stop;
        n_req_type = r_req_type;
        n_ins      = r_ins;
        n_hd       = r_hd;
        n_wrap     = r_wrap;
        n_late     = r_late;
        n_id       = r_id;
        n_iv       = r_iv;
        n_rep      = r_rep;
        n_start    = r_start;
        n_now      = r_now;
        n_o_strobe = 1'b0;
        n_o_kind   = r_o_kind;
        n_o_id     = r_o_id;
        n_o_time   = r_o_time;
        n_o_status = r_o_status;
        n_o_delay  = r_o_delay;
        n_o_last   = r_o_last;
        alu_req    = '0;
        ram_we     = 1'b0;
        ram_waddr  = r_w;
        ram_wdata  = r_ins;
        ram_re     = 1'b0;
        ram_raddr  = r_head;
        ins_done   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req_type = i_req_type;
                    n_id       = i_timer_id;
                    n_iv       = i_interval;
                    n_rep      = i_repeat_req;
                    n_start    = i_start_time;
                    n_now      = i_now_time;
                    n_fires    = '0;
                    n_stop     = 1'b0;
                    n_state    = (i_req_type == REQ_SHOOT) ? S_SH_READ : S_ADD_SUM;
                end
            end
            S_ADD_SUM: begin
                alu_req.a = (r_start != '0) ? r_start : r_now;
                alu_req.b = r_iv;
                n_ins     = '{fire_time: alu_sum, interval: r_iv, ident: r_id, rep: r_rep};
                n_wrap    = alu_carry;
                if (r_count == CW'(DEPTH)) begin
                    n_o_strobe = 1'b1;
                    n_o_kind   = K_ACK;
                    n_o_id     = r_id;
                    n_o_time   = alu_sum;
                    n_o_status = ST_FULL;
                    n_o_delay  = '0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_w     = r_tail;
                    n_k     = r_count;
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (r_k == '0) begin
                    ram_we   = 1'b1;
                    ins_done = 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_prev(r_w);
                    n_state   = S_INS_WAIT;
                end
            end
            S_INS_WAIT: begin
                alu_req.a   = r_ins.fire_time;
                alu_req.b   = ram_q.fire_time;
                alu_req.sub = 1'b1;
                ram_we      = 1'b1;
                if (!alu_carry) begin
                    ram_wdata = ram_q;
                    n_w       = ptr_prev(r_w);
                    n_k       = r_k - CW'(1);
                    n_state   = S_INS_CHK;
                end else begin
                    ins_done = 1'b1;
                end
            end
            S_SH_READ: begin
                if (r_count == '0) begin
                    n_o_strobe = 1'b1;
                    n_o_kind   = K_DONE;
                    n_o_id     = '0;
                    n_o_time   = '0;
                    n_o_status = ST_EMPTY;
                    n_o_delay  = r_default_delay;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = r_stop ? S_SH_FINAL : S_SH_HEAD;
                end
            end
            S_SH_HEAD: begin
                alu_req.a   = r_now;
                alu_req.b   = ram_q.fire_time;
                alu_req.sub = 1'b1;
                if (alu_carry) begin
                    n_hd    = ram_q;
                    n_late  = alu_sum;
                    n_head  = ptr_next(r_head);
                    n_count = r_count - CW'(1);
                    if (ram_q.rep) begin
                        n_state = S_SH_REQ;
                    end else begin
                        n_o_strobe = 1'b1;
                        n_o_kind   = K_FIRE;
                        n_o_id     = ram_q.ident;
                        n_o_time   = ram_q.fire_time;
                        n_o_status = ST_OK;
                        n_o_delay  = '0;
                        n_o_last   = 1'b0;
                        n_state    = S_SH_LAG;
                    end
                end else begin
                    n_state = S_SH_FINAL;
                end
            end
            S_SH_REQ: begin
                alu_req.a = (r_hd.fire_time != '0) ? r_hd.fire_time : r_now;
                alu_req.b = r_hd.interval;
                n_ins     = '{fire_time: alu_sum, interval: r_hd.interval,
                              ident: r_hd.ident, rep: r_hd.rep};
                n_wrap    = alu_carry;
                n_w       = r_tail;
                n_k       = r_count;
                n_state   = S_INS_CHK;
            end
            S_SH_LAG: begin
                alu_req.a   = r_lag_limit;
                alu_req.b   = r_late;
                alu_req.sub = 1'b1;
                n_fires     = r_fires + FW'(1);
                if (!alu_carry || r_fires == FW'(MAX_FIRES - 1)) begin
                    n_stop = 1'b1;
                end
                n_state = S_SH_READ;
            end
            S_SH_FINAL: begin
                alu_req.a   = ram_q.fire_time;
                alu_req.b   = r_now;
                alu_req.sub = 1'b1;
                n_o_strobe  = 1'b1;
                n_o_kind    = K_DONE;
                n_o_id      = '0;
                n_o_time    = '0;
                n_o_last    = 1'b1;
                if (!alu_carry) begin
                    n_o_status = ST_PARADOX;
                    n_o_delay  = r_default_delay;
                end else begin
                    n_o_status = ST_OK;
                    n_o_delay  = alu_sum;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ins_done) begin
            n_count    = r_count + CW'(1);
            n_tail     = ptr_next(r_tail);
            n_o_strobe = 1'b1;
            n_o_status = r_wrap ? ST_WRAP : ST_OK;
            n_o_delay  = '0;
            if (r_req_type == REQ_ADD) begin
                n_o_kind = K_ACK;
                n_o_id   = r_ins.ident;
                n_o_time = r_ins.fire_time;
                n_o_last = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_o_kind = K_FIRE;
                n_o_id   = r_hd.ident;
                n_o_time = r_hd.fire_time;
                n_o_last = 1'b0;
                n_state  = S_SH_LAG;
            end
        end
    end

    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_head          <= '0;
            r_tail          <= '0;
            r_count         <= '0;
            r_w             <= '0;
            r_k             <= '0;
            r_fires         <= '0;
            r_stop          <= 1'b0;
            r_req_type      <= REQ_ADD;
            r_o_strobe      <= 1'b0;
            r_default_delay <= DEFAULT_DELAY_RST;
            r_lag_limit     <= LAG_LIMIT_RST;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_w        <= n_w;
            r_k        <= n_k;
            r_fires    <= n_fires;
            r_stop     <= n_stop;
            r_req_type <= n_req_type;
            r_o_strobe <= n_o_strobe;
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_DEFAULT_DELAY: r_default_delay <= pwdata;
                    REG_LAG_LIMIT:     r_lag_limit     <= pwdata;
                    default:           r_lag_limit     <= r_lag_limit;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins      <= n_ins;
        r_hd       <= n_hd;
        r_wrap     <= n_wrap;
        r_late     <= n_late;
        r_id       <= n_id;
        r_iv       <= n_iv;
        r_rep      <= n_rep;
        r_start    <= n_start;
        r_now      <= n_now;
        r_o_kind   <= n_o_kind;
        r_o_id     <= n_o_id;
        r_o_time   <= n_o_time;
        r_o_status <= n_o_status;
        r_o_delay  <= n_o_delay;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        unique case (paddr[2])
            REG_DEFAULT_DELAY: prdata = r_default_delay;
            REG_LAG_LIMIT:     prdata = r_lag_limit;
            default:           prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_o_strobe;
    assign o_kind       = r_o_kind;
    assign o_fired_id   = r_o_id;
    assign o_fire_time  = r_o_time;
    assign o_status     = r_o_status;
    assign o_next_delay = r_o_delay;
    assign o_last       = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> o_kind != K_FIRE)
        else $error("fire result marked last");

    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_kind == K_FIRE |-> busy)
        else $error("idle after fire before shoot done");

endmodule

// ----- verif/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam int DEPTH         = 32;
    localparam int MAX_FIRES     = 63;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic              req;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] iv;
        logic              rep;
        logic [DATA_W-1:0] start_t;
        logic [DATA_W-1:0] now_t;
        bit                drain_first;
    } t_timer_req;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] ftime;
        logic [2:0]        status;
        logic [DATA_W-1:0] delay;
        logic              last;
    } t_timer_event;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_req_type = 1'b0;
    logic [ID_W-1:0]   i_timer_id = '0;
    logic [DATA_W-1:0] i_interval = '0;
    logic              i_repeat_req = 1'b0;
    logic [DATA_W-1:0] i_start_time = '0;
    logic [DATA_W-1:0] i_now_time = '0;
    logic              o_strobe;
    logic [1:0]        o_kind;
    logic [ID_W-1:0]   o_fired_id;
    logic [DATA_W-1:0] o_fire_time;
    logic [2:0]        o_status;
    logic [DATA_W-1:0] o_next_delay;
    logic              o_last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    t_timer_req        request_fifo[$];
    t_timer_event      timer_events[$];
    t_entry            timer_list[$];
    t_timer_event      seen_event;
    logic [DATA_W-1:0] cfg_default_delay = DEFAULT_DELAY_RST;
    logic [DATA_W-1:0] cfg_lag_limit = LAG_LIMIT_RST;
    logic [DATA_W-1:0] sim_now = '0;
    int                send_idle_pct = 0;
    int                mismatches = 0;
    int                stall_cycles = 0;

    sorted_timer_queue #(
        .DEPTH     (DEPTH),
        .MAX_FIRES (MAX_FIRES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_timer_id   (i_timer_id),
        .i_interval   (i_interval),
        .i_repeat_req (i_repeat_req),
        .i_start_time (i_start_time),
        .i_now_time   (i_now_time),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_fired_id   (o_fired_id),
        .o_fire_time  (o_fire_time),
        .o_status     (o_status),
        .o_next_delay (o_next_delay),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ties go after entries with equal time
    function automatic void place_timer(t_entry e);
        int pos = 0;
        while (pos < timer_list.size() && timer_list[pos].fire_time <= e.fire_time)
            pos++;
        timer_list.insert(pos, e);
    endfunction

    function automatic void compute_timer_events(t_timer_req r);
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] t;
        logic [2:0]        st;
        int                fires;
        t_entry            head;
        t_entry            requeued;
        if (r.req == REQ_ADD) begin
            base = (r.start_t != 0) ? r.start_t : r.now_t;
            t = base + r.iv;
            st = (t < base) ? ST_WRAP : ST_OK;
            if (timer_list.size() >= DEPTH) begin
                st = ST_FULL;
            end else begin
                place_timer('{fire_time: t, interval: r.iv, ident: r.id, rep: r.rep});
            end
            timer_events.push_back('{K_ACK, r.id, t, st, '0, 1'b1});
            return;
        end
        fires = 0;
        while (fires < MAX_FIRES && timer_list.size() > 0
               && timer_list[0].fire_time <= r.now_t) begin
            head = timer_list.pop_front();
            st = ST_OK;
            if (head.rep) begin
                base = (head.fire_time != 0) ? head.fire_time : r.now_t;
                t = base + head.interval;
                if (t < base)
                    st = ST_WRAP;
                requeued = head;
                requeued.fire_time = t;
                place_timer(requeued);
            end
            timer_events.push_back('{K_FIRE, head.ident, head.fire_time, st, '0, 1'b0});
            fires++;
            if (r.now_t - head.fire_time > cfg_lag_limit)
                break;
        end
        if (timer_list.size() == 0) begin
            timer_events.push_back('{K_DONE, '0, '0, ST_EMPTY, cfg_default_delay, 1'b1});
        end else if (timer_list[0].fire_time < r.now_t) begin
            timer_events.push_back('{K_DONE, '0, '0, ST_PARADOX, cfg_default_delay, 1'b1});
        end else begin
            timer_events.push_back('{K_DONE, '0, '0, ST_OK,
                                     timer_list[0].fire_time - r.now_t, 1'b1});
        end
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] exp_v,
                                        logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    function automatic void push_req(logic req, logic [ID_W-1:0] id, logic [DATA_W-1:0] iv,
                                     logic rep, logic [DATA_W-1:0] st,
                                     logic [DATA_W-1:0] now_t);
        request_fifo.push_back('{req, id, iv, rep, st, now_t, 1'b0});
    endfunction

    // mostly a coherent timeline around sim_now, with some raw noise
    function automatic t_timer_req random_request();
        t_timer_req r;
        int         roll;
        roll = $urandom_range(0, 99);
        r.id = ID_W'($urandom);
        r.iv = $urandom;
        r.rep = 1'($urandom);
        r.start_t = $urandom;
        r.now_t = $urandom;
        r.drain_first = 1'b0;
        if (roll < 10) begin
            r.req = 1'($urandom);
            if (r.req == REQ_ADD)
                r.rep = 1'b0;
        end else if (roll < 60) begin
            r.req = REQ_ADD;
            r.rep = ($urandom_range(0, 99) < 20);
            r.iv = r.rep ? $urandom_range(64, 2000) : $urandom_range(0, 3000);
            r.start_t = $urandom_range(0, 1) ? '0 : sim_now + $urandom_range(1, 500);
            r.now_t = sim_now;
        end else begin
            r.req = REQ_SHOOT;
            sim_now += ($urandom_range(0, 19) == 0) ? $urandom_range(2000, 40000)
                                                     : $urandom_range(0, 400);
            r.now_t = sim_now;
        end
        return r;
    endfunction

    task automatic wait_idle();
        while (request_fifo.size() != 0 || timer_events.size() != 0 || start || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_DEFAULT_DELAY)
            cfg_default_delay = value;
        else
            cfg_lag_limit = value;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                compute_timer_events(request_fifo.pop_front());
            end
            if (!start || !busy) begin
                if (request_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                    && !(request_fifo[0].drain_first
                         && (timer_events.size() != 0 || busy))) begin
                    start <= 1'b1;
                    i_req_type <= request_fifo[0].req;
                    i_timer_id <= request_fifo[0].id;
                    i_interval <= request_fifo[0].iv;
                    i_repeat_req <= request_fifo[0].rep;
                    i_start_time <= request_fifo[0].start_t;
                    i_now_time <= request_fifo[0].now_t;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (timer_events.size() == 0) begin
                $display("%0t: unexpected result expected none got kind %0d id %0h time %0h",
                         $time, o_kind, o_fired_id, o_fire_time);
                mismatches++;
            end else begin
                seen_event = timer_events.pop_front();
                check_field("kind", DATA_W'(seen_event.kind), DATA_W'(o_kind));
                check_field("fired_id", DATA_W'(seen_event.id), DATA_W'(o_fired_id));
                check_field("fire_time", seen_event.ftime, o_fire_time);
                check_field("status", DATA_W'(seen_event.status), DATA_W'(o_status));
                check_field("next_delay", seen_event.delay, o_next_delay);
                check_field("last", DATA_W'(seen_event.last), DATA_W'(o_last));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        // directed: empty, wrap on add and on requeue, zero fire time, ties,
        // zero base, max fires, paradox
        push_req(REQ_SHOOT, ID_W'($urandom), $urandom, 1'($urandom), $urandom, 32'h0);
        push_req(REQ_ADD, 8'hA5, 32'h80, 1'b1, 32'hFFFF_FF00, 32'h1234_5678);
        push_req(REQ_SHOOT, ID_W'($urandom), $urandom, 1'($urandom), $urandom, 32'hFFFF_FFA0);
        push_req(REQ_SHOOT, ID_W'($urandom), $urandom, 1'($urandom), $urandom, 32'h10);
        push_req(REQ_SHOOT, ID_W'($urandom), $urandom, 1'($urandom), $urandom, 32'h20);
        push_req(REQ_ADD, 8'h01, 32'd100, 1'b0, 32'h0, 32'h40);
        push_req(REQ_ADD, 8'h02, 32'h64, 1'b0, 32'h40, 32'h0);
        push_req(REQ_ADD, 8'h00, 32'h0, 1'b0, 32'h0, 32'h0);
        push_req(REQ_ADD, 8'hFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(REQ_SHOOT, ID_W'($urandom), $urandom, 1'($urandom), $urandom, 32'hA4);
        push_req(REQ_ADD, 8'h07, 32'd16, 1'b1, 32'h0, 32'h200);
        push_req(REQ_SHOOT, ID_W'($urandom), $urandom, 1'($urandom), $urandom, 32'h670);
        push_req(REQ_ADD, 8'h5A, 32'h0, 1'b0, 32'h680, 32'h670);
        push_req(REQ_SHOOT, ID_W'($urandom), $urandom, 1'($urandom), $urandom, 32'h670);
        push_req(REQ_SHOOT, ID_W'($urandom), $urandom, 1'($urandom), $urandom, 32'h600);
        push_req(REQ_SHOOT, ID_W'($urandom), $urandom, 1'($urandom), $urandom, 32'h700);
        sim_now = 32'h700;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // fill to capacity, then random traffic with no lag cutoff
        write_reg(REG_DEFAULT_DELAY, 32'h0);
        write_reg(REG_LAG_LIMIT, 32'hFFFF_FFFF);
        for (int n = 0; n < 34; n++)
            push_req(REQ_ADD, ID_W'($urandom), $urandom_range(100, 3000), 1'b0, 32'h0,
                     sim_now);
        for (int n = 0; n < 10; n++)
            request_fifo.push_back(random_request());
        wait_idle();

        // sender idles often, stops after every late fire, drains now and then
        send_idle_pct = 59;
        write_reg(REG_DEFAULT_DELAY, 32'hFFFF_FFFF);
        write_reg(REG_LAG_LIMIT, 32'h0);
        for (int n = 0; n < 30; n++) begin
            request_fifo.push_back(random_request());
            if (n % 8 == 7)
                request_fifo[$].drain_first = 1'b1;
        end
        wait_idle();

        send_idle_pct = 7;
        write_reg(REG_DEFAULT_DELAY, $urandom);
        write_reg(REG_LAG_LIMIT, $urandom_range(100, 5000));
        for (int n = 0; n < 30; n++)
            request_fifo.push_back(random_request());
        wait_idle();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/sts_pkg.sv
src/sts_ram.sv
src/sts_alu.sv
src/sorted_timer_queue.sv
verif/testbench.sv
